// File: src/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef struct packed {
    req_t                      req_type;
    logic signed [WORD_W-1:0]  push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  rear_value;
    logic [CNT_OUT_W-1:0]      entry_count;
    logic                      is_empty;
    logic                      is_full;
    status_t                   status;
  } out_res_t;

  // per-chain control: insert at head, drop head, write at fill position
  typedef struct packed {
    logic ins;
    logic del;
    logic app;
  } chain_ctl_t;

endpackage

// File: src/double_ended_queue.sv
// channel | ports                        | direction | carries
// request | in_valid in_stall in_req     | in        | req_type, push_value
// result  | out_valid out_stall out_res  | out       | front/rear, count, flags, status
//
// One request per cycle while in_stall is low; its result shows in the cycle after acceptance.
// Two rows of DEPTH cells hold the entries, one front-aligned, one rear-aligned;
// every cell updates from its neighbors in the same cycle.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// in_stall follows out_stall while a result is waiting.
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::out_res_t out_res
);
  import deq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  status_t       status_r, status_nxt;
  chain_ctl_t    f_ctl, r_ctl;
  logic          in_acc, empty, full;
  logic signed [WORD_W-1:0] f_head, r_head;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    f_ctl      = '0;
    r_ctl      = '0;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (in_acc) begin
      case (in_req.req_type)
        REQ_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            f_ctl.ins = 1'b1;
            r_ctl.app = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        REQ_PUSH_REAR: begin
          if (full) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            r_ctl.ins = 1'b1;
            f_ctl.app = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            f_ctl.del = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          if (empty) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            r_ctl.del = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
        status_r    <= status_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  deq_chain #(.DEPTH(DEPTH), .CW(CW)) u_front (
    .clk   (clk),
    .ctl   (f_ctl),
    .count (count_r),
    .data  (in_req.push_value),
    .head  (f_head)
  );

  deq_chain #(.DEPTH(DEPTH), .CW(CW)) u_rear (
    .clk   (clk),
    .ctl   (r_ctl),
    .count (count_r),
    .data  (in_req.push_value),
    .head  (r_head)
  );

  assign out_valid           = out_valid_r;
  assign out_res.front_value = empty ? '0 : f_head;
  assign out_res.rear_value  = empty ? '0 : r_head;
  assign out_res.entry_count = CNT_OUT_W'(count_r);
  assign out_res.is_empty    = empty;
  assign out_res.is_full     = full;
  assign out_res.status      = status_r;

endmodule

// File: src/deq_cell.sv
module deq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                                clk,
  input  deq_pkg::chain_ctl_t                 ctl,
  input  logic [CW-1:0]                       count,
  input  logic signed [deq_pkg::WORD_W-1:0]   data,
  input  logic signed [deq_pkg::WORD_W-1:0]   left_q,
  input  logic signed [deq_pkg::WORD_W-1:0]   right_q,
  output logic signed [deq_pkg::WORD_W-1:0]   word_r
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      word_nxt = left_q;
    end else if (ctl.del) begin
      word_nxt = right_q;
    end else if (ctl.app && (count == CW'(IDX))) begin
      word_nxt = data;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// File: src/deq_chain.sv
module deq_chain #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  deq_pkg::chain_ctl_t                 ctl,
  input  logic [CW-1:0]                       count,
  input  logic signed [deq_pkg::WORD_W-1:0]   data,
  output logic signed [deq_pkg::WORD_W-1:0]   head
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_q;
    logic signed [WORD_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = data;
    end else begin : g_mid
      assign left_q = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = words[i];
    end else begin : g_inner
      assign right_q = words[i+1];
    end

    deq_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count),
      .data    (data),
      .left_q  (left_q),
      .right_q (right_q),
      .word_r  (words[i])
    );
  end

  assign head = words[0];

endmodule

// File: src/deq_chk.sv
module deq_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input deq_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input deq_pkg::out_res_t out_res
);
  import deq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request gave no result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.is_empty |-> out_res.front_value == '0 &&
      out_res.rear_value == '0 && !out_res.is_full)
    else $error("empty queue shows data or full");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
      (in_req.req_type == REQ_PUSH_FRONT || in_req.req_type == REQ_PUSH_REAR)
    |=> !out_res.is_empty && (out_res.status == ST_DONE || out_res.status == ST_PUSH_FULL))
    else $error("push left queue empty or bad status");

endmodule

bind double_ended_queue deq_chk u_deq_chk (.*);
